[rtl/dhp_pkg.sv]
// Shared types and constants of the deduplicating hash pool.
package dhp_pkg;

  localparam int unsigned DepthDefault = 1024;
  localparam int unsigned HashBits     = 32;
  localparam int unsigned TagBits      = 16;
  localparam int unsigned IndexBits    = 10;
  localparam int unsigned CountBits    = 11;
  localparam int unsigned StatusBits   = 3;
  localparam int unsigned PaddrBits    = 3;
  localparam int unsigned DataBits     = 32;

  localparam logic [CountBits-1:0] CapacityReset = 11'd1000;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [StatusBits-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_READ_OK   = 3'd3,
    STAT_RANGE     = 3'd4,
    STAT_CLEARED   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    KIND_INSERT,
    KIND_READ,
    KIND_CLEAR
  } kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_e;

  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0
  } reg_e;

  typedef struct packed {
    logic [1:0]           op;
    logic [HashBits-1:0]  entry_hash;
    logic [TagBits-1:0]   entry_tag;
    logic [IndexBits-1:0] read_index;
  } in_t;

  typedef struct packed {
    logic [StatusBits-1:0] status;
    logic [HashBits-1:0]   out_hash;
    logic [TagBits-1:0]    out_tag;
    logic [CountBits-1:0]  entry_count;
  } out_t;

  // Classified transaction as it sits in the queue between front and back.
  typedef struct packed {
    kind_e                kind;
    logic [HashBits-1:0]  hash;
    logic [TagBits-1:0]   tag;
    logic [IndexBits-1:0] idx;
  } item_t;

  typedef struct packed {
    logic [HashBits-1:0] hash;
    logic [TagBits-1:0]  tag;
  } entry_t;

endpackage

[rtl/dhp_front.sv]
// Input side: accepts transactions, decodes the op and queues them.
module dhp_front import dhp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  in_t   in_data_i,
  output logic  item_valid_o,
  output item_t item_o,
  input  logic  item_pop_i
);

  item_t       entries_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  kind_e       kind;

  // Unused op code is served as a read.
  always_comb begin
    unique case (in_data_i.op)
      OP_INSERT: kind = KIND_INSERT;
      OP_CLEAR:  kind = KIND_CLEAR;
      default:   kind = KIND_READ;
    endcase
  end

  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (item_pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push && !item_pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && item_pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= '{kind: kind, hash: in_data_i.entry_hash,
                               tag: in_data_i.entry_tag, idx: in_data_i.read_index};
    end
  end

endmodule

[rtl/dhp_back.sv]
// Execution side: entry memory, duplicate scan, count and result register.
module dhp_back import dhp_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CountBits-1:0] cap_i,
  input  logic                 item_valid_i,
  input  item_t                item_i,
  output logic                 item_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CountMax = (1 << CountBits) - 1;
  localparam logic [CountBits-1:0] LimitCap =
    CountBits'((DEPTH > CountMax) ? CountMax : DEPTH);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  state_e               state_q, state_d;
  status_e              pend_q, pend_d;
  logic [CountBits-1:0] count_q, count_d;
  logic [CountBits-1:0] ptr_q, ptr_d;
  logic                 issued_q, issued_d;
  logic                 res_valid_q, res_valid_d;
  out_t                 res_q, res_d;

  logic [CountBits-1:0] eff_limit;
  logic                 pool_full, idx_ok, res_free, load;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr, mem_raddr;

  assign eff_limit = (cap_i < LimitCap) ? cap_i : LimitCap;
  assign pool_full = (count_q >= eff_limit);
  assign idx_ok    = (CountBits'(item_i.idx) < count_q) && (32'(item_i.idx) < 32'(DEPTH));
  assign res_free  = !res_valid_q || out_ready_i;

  assign mem_waddr = AW'(count_q);
  assign mem_raddr = (state_q == S_SCAN) ? AW'(ptr_q) : AW'(item_i.idx);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= '{hash: item_i.hash, tag: item_i.tag};
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    count_d    = count_q;
    ptr_d      = ptr_q;
    issued_d   = 1'b0;
    mem_we     = 1'b0;
    load       = 1'b0;
    item_pop_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          unique case (item_i.kind)
            KIND_CLEAR: begin
              count_d = '0;
              pend_d  = STAT_CLEARED;
              state_d = S_RESP;
            end
            KIND_INSERT: begin
              if (pool_full) begin
                pend_d  = STAT_FULL;
                state_d = S_RESP;
              end else begin
                ptr_d   = '0;
                state_d = S_SCAN;
              end
            end
            default: begin
              // Read issued this cycle, data lands in rdata_q for S_RESP.
              pend_d  = idx_ok ? STAT_READ_OK : STAT_RANGE;
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        // One read per cycle; the compare works on the data read for the previous address.
        if (issued_q && (rdata_q.hash == item_i.hash)) begin
          pend_d  = STAT_DUPLICATE;
          state_d = S_RESP;
        end else if (ptr_q == count_q) begin
          mem_we  = 1'b1;
          count_d = count_q + CountBits'(1);
          pend_d  = STAT_INSERTED;
          state_d = S_RESP;
        end else begin
          issued_d = 1'b1;
          ptr_d    = ptr_q + CountBits'(1);
        end
      end
      S_RESP: begin
        if (res_free) begin
          load       = 1'b1;
          item_pop_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    res_d             = res_q;
    res_valid_d       = res_valid_q && !out_ready_i;
    if (load) begin
      res_valid_d       = 1'b1;
      res_d.status      = pend_q;
      res_d.out_hash    = (pend_q == STAT_READ_OK) ? rdata_q.hash : '0;
      res_d.out_tag     = (pend_q == STAT_READ_OK) ? rdata_q.tag : '0;
      res_d.entry_count = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= STAT_INSERTED;
      count_q     <= '0;
      ptr_q       <= '0;
      issued_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      issued_q    <= issued_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

endmodule

[rtl/dedup_hash_pool_core.sv]
// Top level of the deduplicating hash pool: register port, front and back.
//
// A bounded pool of (hash, tag) entries. An insert transaction is dropped as
// full when the held count has reached min(capacity_limit, DEPTH); otherwise
// every held hash is compared against the new one and a match drops it as a
// duplicate, else the entry is appended at the current count. A read returns
// the entry at read_index, or status "out of range" with zero hash and tag
// when the index is not below the count. A clear sets the count to zero
// (data stays in memory but is unreachable). Op code 3 acts as a read.
// Every transaction yields exactly one result carrying the count after it.
// Timing: a front queue of two transactions decouples the input from the
// execution engine. The engine has one memory read port and scans it one
// entry per cycle; an insert goes S_IDLE, S_SCAN over the held entries,
// S_RESP, a full drop, read or clear goes S_IDLE, S_RESP, and S_RESP loads
// the result register once it is free. The result register lets the next
// transaction be accepted while a result waits. capacity_limit (reset
// 1000) sits at byte address 0 of the register port; the user must write
// it only while the block is idle, the block itself does not enforce it.
module dedup_hash_pool_core import dhp_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input channel
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  // Result channel
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o,
  // Register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrBits-1:0] paddr,
  input  logic [DataBits-1:0]  pwdata,
  output logic [DataBits-1:0]  prdata,
  output logic                 pready
);

  logic [CountBits-1:0] cap_q, cap_d;
  logic                 reg_wr;
  logic                 item_valid, item_pop;
  item_t                item;

  // Register index is the word address.
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2:2] == REG_CAPACITY) ? DataBits'(cap_q) : '0;

  always_comb begin
    cap_d = cap_q;
    if (reg_wr && (paddr[2:2] == REG_CAPACITY)) begin
      cap_d = pwdata[CountBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapacityReset;
    end else begin
      cap_q <= cap_d;
    end
  end

  dhp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  dhp_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cap_i        (cap_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

[verif/dhp_pool_checker.sv]
// Checker of the hash pool: mirrors the pool state and compares every result.
module dhp_pool_checker import dhp_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_t                  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_t                 out_data_i,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic                 pready_i,
  input  logic [PaddrBits-1:0] paddr_i,
  input  logic [DataBits-1:0]  pwdata_i,
  input  logic [DataBits-1:0]  prdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam logic [PaddrBits-1:0] CapAddr = PaddrBits'(REG_CAPACITY) << 2;

  logic [HashBits-1:0]  pool_hash [DEPTH];
  logic [TagBits-1:0]   pool_tag  [DEPTH];
  int unsigned          held;
  logic [CountBits-1:0] capacity;
  out_t                 awaited_results [$];
  int                   misses = 0;

  assign fail_count_o = misses;

  // Counts a failure; true while detailed reports are still allowed.
  function automatic bit report_slot();
    report_slot = (misses < 10);
    misses++;
  endfunction

  // Applies one transaction to the mirrored pool and forms its result.
  task automatic pool_predict(input in_t t, output out_t r);
    int unsigned lim;
    bit          seen;
    lim  = (capacity < DEPTH) ? capacity : DEPTH;
    seen = 1'b0;
    r    = '0;
    case (t.op)
      OP_INSERT: begin
        if (held >= lim) begin
          r.status = STAT_FULL;
        end else begin
          for (int unsigned i = 0; i < held; i++) begin
            if (pool_hash[i] == t.entry_hash) seen = 1'b1;
          end
          if (seen) begin
            r.status = STAT_DUPLICATE;
          end else begin
            pool_hash[held] = t.entry_hash;
            pool_tag[held]  = t.entry_tag;
            held++;
            r.status = STAT_INSERTED;
          end
        end
      end
      OP_CLEAR: begin
        held     = 0;
        r.status = STAT_CLEARED;
      end
      default: begin
        // read, and the spare op code acts the same
        if (t.read_index < held) begin
          r.out_hash = pool_hash[t.read_index];
          r.out_tag  = pool_tag[t.read_index];
          r.status   = STAT_READ_OK;
        end else begin
          r.status = STAT_RANGE;
        end
      end
    endcase
    r.entry_count = CountBits'(held);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    out_t got;
    if (!rst_ni) begin
      held     = 0;
      capacity = CapacityReset;
      awaited_results.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (awaited_results.size() == 0) begin
          if (report_slot())
            $display("unexpected result: status %0d hash %h tag %h count %0d",
                     got.status, got.out_hash, got.out_tag, got.entry_count);
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status || got.out_hash !== want.out_hash ||
              got.out_tag !== want.out_tag || got.entry_count !== want.entry_count) begin
            if (report_slot())
              $display("mismatch: exp status %0d hash %h tag %h count %0d / got %0d %h %h %0d",
                       want.status, want.out_hash, want.out_tag, want.entry_count,
                       got.status, got.out_hash, got.out_tag, got.entry_count);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        pool_predict(in_data_i, want);
        awaited_results.push_back(want);
      end
      if (psel_i && penable_i && pready_i && paddr_i == CapAddr) begin
        if (pwrite_i) begin
          capacity = pwdata_i[CountBits-1:0];
        end else if (prdata_i !== DataBits'(capacity)) begin
          if (report_slot())
            $display("capacity readback: exp %0d got %0d", capacity, prdata_i);
        end
      end
      pending_o <= awaited_results.size();
    end
  end

endmodule

[verif/tb.sv]
// Testbench top of the hash pool: stimulus, register setup and verdict.
module tb;
  import dhp_pkg::*;

  // Spare op code; the block treats it as a read.
  localparam logic [1:0]           OpSpare = 2'd3;
  localparam logic [PaddrBits-1:0] CapAddr = PaddrBits'(REG_CAPACITY) << 2;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_t                  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_t                 out_data_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [PaddrBits-1:0] paddr       = '0;
  logic [DataBits-1:0]  pwdata      = '0;
  logic [DataBits-1:0]  prdata;
  logic                 pready;

  int          fail_count;
  int          pending;     // transactions accepted whose result is still due
  bit          calm = 1'b0; // set during the stretch without idling
  int unsigned cap_steps [10];

  dedup_hash_pool_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  dhp_pool_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .prdata_i    (prdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result side backpressure: about 18% stall, none while calm.
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(99) >= 18);
  end

  // Presents one transaction and returns at the edge that accepts it. Valid
  // stays high afterwards so back-to-back transactions need no extra edge;
  // it drops only for a random gap or when the bench stops sending.
  task automatic send_op(input logic [1:0] op, input logic [HashBits-1:0] h,
                         input logic [TagBits-1:0] tg, input logic [IndexBits-1:0] idx);
    if (!calm && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 40);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= in_t'{op: op, entry_hash: h, entry_tag: tg, read_index: idx};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // One register access: setup cycle, then access until pready.
  task automatic reg_access(input logic wr, input logic [DataBits-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= CapAddr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drains the pool of outstanding work, then writes and reads back the limit.
  task automatic set_capacity(input int unsigned value);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    reg_access(1'b1, DataBits'(value));
    reg_access(1'b0, '0);
  endtask

  // Random traffic. Hashes come mostly from a small pool so duplicates are
  // frequent; indexes mostly stay below 48 so reads hit both ways.
  task automatic random_phase(input int n);
    int                   r;
    logic [1:0]           op;
    logic [HashBits-1:0]  h;
    logic [IndexBits-1:0] idx;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 55)      op = OP_INSERT;
      else if (r < 85) op = OP_READ;
      else if (r < 92) op = OpSpare;
      else             op = OP_CLEAR;
      r = $urandom_range(99);
      if (r < 50)      h = HashBits'($urandom_range(47));
      else if (r < 60) h = 32'hFFFF_FF00 | HashBits'($urandom_range(15));
      else             h = $urandom();
      r = $urandom_range(99);
      if (r < 70)      idx = IndexBits'($urandom_range(47));
      else if (r < 80) idx = '1;
      else             idx = IndexBits'($urandom_range(1023));
      send_op(op, h, TagBits'($urandom()), idx);
    end
  endtask

  initial begin
    cap_steps = '{16, 1, 1000, 0, 5, 1024, 2047, 64, 3, 200};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // limit must read back its reset value before any write
    reg_access(1'b0, '0);

    // extremes of hash and tag, duplicates, reads in and out of range
    send_op(OP_INSERT, '0, '0, '0);
    send_op(OP_INSERT, '1, '1, '0);
    send_op(OP_INSERT, '0, 16'h1234, '0);
    send_op(OP_INSERT, '1, '0, '1);
    send_op(OP_READ, '0, '0, 10'd0);
    send_op(OP_READ, '1, '1, 10'd1);
    send_op(OP_READ, '0, '0, 10'd2);
    send_op(OP_READ, '0, '0, '1);
    send_op(OpSpare, '0, '0, 10'd1);
    send_op(OpSpare, '0, '0, '1);
    // after a clear the old entries are unreachable and may be reinserted
    send_op(OP_CLEAR, '1, '1, '1);
    send_op(OP_READ, '0, '0, 10'd0);
    send_op(OP_INSERT, '0, 16'hA5A5, '0);
    send_op(OP_CLEAR, '0, '0, '0);

    // small limit: third insert is full, and full wins over duplicate
    set_capacity(2);
    send_op(OP_INSERT, 32'h1111_1111, 16'h0001, '0);
    send_op(OP_INSERT, 32'h2222_2222, 16'h0002, '0);
    send_op(OP_INSERT, 32'h3333_3333, 16'h0003, '0);
    send_op(OP_INSERT, 32'h1111_1111, 16'h0004, '0);

    // limit dropped below the held count keeps the entries
    set_capacity(1);
    send_op(OP_INSERT, 32'h4444_4444, 16'h0005, '0);
    send_op(OP_READ, '0, '0, 10'd1);

    // zero limit refuses every insert
    set_capacity(0);
    send_op(OP_CLEAR, '0, '0, '0);
    send_op(OP_INSERT, 32'h5555_5555, 16'h0006, '0);

    // limit above depth behaves as depth
    set_capacity(2047);
    send_op(OP_INSERT, 32'h5555_5555, 16'h0007, '0);
    send_op(OP_READ, '0, '0, 10'd0);

    foreach (cap_steps[i]) begin
      set_capacity(cap_steps[i]);
      calm <= (i == 4 || i == 5);
      random_phase(40);
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #80000000;
    $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
rtl/dhp_pkg.sv
rtl/dhp_front.sv
rtl/dhp_back.sv
rtl/dedup_hash_pool_core.sv
verif/dhp_pool_checker.sv
verif/tb.sv
